[design/efws_pkg.sv]
// Shared types and constants for the earliest-free-worker scheduler.
// Used by efws_ctrl, efws_dp and earliest_free_worker_scheduler.
package efws_pkg;

  localparam int unsigned DUR_W = 32;
  localparam int unsigned TIME_W = 63;
  localparam int unsigned IDX_W = 4;
  localparam int unsigned CNT_W = 5;
  localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_CMP   = 4'b1000
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic cfg_wr;    // take a new worker count
    logic clr_step;  // write one entry of the clearing pass
    logic accept;    // take a job: load result, start the sift
    logic rd;        // read both children of the current position
    logic cmp;       // compare and write back one level
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_last;   // clearing pass writes its final entry
    logic sift_done;  // sift ends at this level
  } dp_sts_t;

endpackage

[design/efws_ctrl.sv]
// Sequencer for the earliest-free-worker scheduler: clearing pass, sift
// levels and the result handshake. Depends on efws_pkg.
module efws_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  output efws_pkg::dp_cmd_t cmd_o,
  input  efws_pkg::dp_sts_t sts_i
);

  efws_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic in_xfer, cfg_xfer;

  // Configuration is always taken; it restarts the clearing pass
  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i;

  // Take a job only when idle and the result register is free or draining
  assign in_ready_o = (state_q == efws_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_xfer    = in_valid_i && in_ready_o;

  // Drive datapath commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.cfg_wr   = cfg_xfer;
    cmd_o.clr_step = (state_q == efws_pkg::ST_CLEAR) && !cfg_xfer;
    cmd_o.accept   = in_xfer;
    cmd_o.rd       = (state_q == efws_pkg::ST_READ);
    cmd_o.cmp      = (state_q == efws_pkg::ST_CMP);
  end

  // Advance the state machine
  always_comb begin
    state_d = state_q;
    case (state_q)
      efws_pkg::ST_CLEAR: if (sts_i.clr_last) state_d = efws_pkg::ST_IDLE;
      efws_pkg::ST_IDLE:  if (in_xfer) state_d = efws_pkg::ST_READ;
      efws_pkg::ST_READ:  state_d = efws_pkg::ST_CMP;
      efws_pkg::ST_CMP: begin
        state_d = sts_i.sift_done ? efws_pkg::ST_IDLE : efws_pkg::ST_READ;
      end
      default: state_d = efws_pkg::ST_CLEAR;
    endcase
    if (cfg_xfer) state_d = efws_pkg::ST_CLEAR;
  end

  // Hold the result valid until its transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (in_xfer) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= efws_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[design/efws_dp.sv]
// Datapath of the earliest-free-worker scheduler: heap memory, root copy,
// sift registers, worker count and result register. Depends on efws_pkg.
module efws_dp #(
  parameter int unsigned MAX_WORKERS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  efws_pkg::dp_cmd_t             cmd_i,
  output efws_pkg::dp_sts_t             sts_o,
  input  logic [efws_pkg::CNT_W-1:0]    cfg_data_i,
  input  logic [efws_pkg::DUR_W-1:0]    job_duration_i,
  output logic [efws_pkg::IDX_W-1:0]    worker_index_o,
  output logic [efws_pkg::TIME_W-1:0]   start_time_o
);

  localparam int unsigned TW = efws_pkg::TIME_W;
  localparam int unsigned AW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int unsigned NW = $clog2(MAX_WORKERS + 1);
  localparam int unsigned IW = NW + 1;
  localparam int unsigned CW = (NW > efws_pkg::CNT_W) ? NW : efws_pkg::CNT_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WORKERS - 1);

  // Heap storage
  logic [TW-1:0] mem_t [MAX_WORKERS];
  logic [AW-1:0] mem_id [MAX_WORKERS];

  logic [efws_pkg::CNT_W-1:0] cnt_q;
  logic [AW-1:0] clr_q, pos_q;
  logic [TW-1:0] root_t_q, cur_t_q, l_t_q, r_t_q, start_q;
  logic [AW-1:0] root_id_q, cur_id_q, l_id_q, r_id_q;
  logic [efws_pkg::IDX_W-1:0] idx_q;

  logic [CW-1:0] cnt_ext, n_cw;
  logic [IW-1:0] n_w, left_w, right_w;
  logic left_ok, right_ok, left_win, right_win;
  logic [TW-1:0] b_t;
  logic [AW-1:0] b_id;
  logic [AW-1:0] l_addr, r_addr;
  logic [TW:0]   sum;
  logic [TW-1:0] next_t;
  logic          wr_en;
  logic [AW-1:0] wr_addr, wr_id;
  logic [TW-1:0] wr_t;

  // Clamp the worker count to 1..MAX_WORKERS
  assign cnt_ext = CW'(cnt_q);
  always_comb begin
    n_cw = cnt_ext;
    if (cnt_ext == '0) n_cw = CW'(1);
    if (cnt_ext > CW'(MAX_WORKERS)) n_cw = CW'(MAX_WORKERS);
  end
  assign n_w = IW'(n_cw);

  // Child positions of the current level
  assign left_w   = (IW'(pos_q) << 1) + IW'(1);
  assign right_w  = left_w + IW'(1);
  assign left_ok  = left_w < n_w;
  assign right_ok = right_w < n_w;
  assign l_addr   = left_ok ? left_w[AW-1:0] : '0;
  assign r_addr   = right_ok ? right_w[AW-1:0] : '0;

  // Pick the smallest of entry, left and right child; ties by worker
  assign left_win = left_ok && ((l_t_q < cur_t_q) ||
                                ((l_t_q == cur_t_q) && (l_id_q < cur_id_q)));
  assign b_t  = left_win ? l_t_q : cur_t_q;
  assign b_id = left_win ? l_id_q : cur_id_q;
  assign right_win = right_ok && ((r_t_q < b_t) || ((r_t_q == b_t) && (r_id_q < b_id)));

  // Stop when the entry stays; a node with no child keeps it on its own level
  assign sts_o.sift_done = !(left_win || right_win);
  assign sts_o.clr_last  = cmd_i.clr_step && (clr_q == LAST_ADDR);

  // Saturating new free time of the root worker
  assign sum    = {1'b0, root_t_q} + (TW+1)'(job_duration_i);
  assign next_t = sum[TW] ? '1 : sum[TW-1:0];

  // Select the heap write
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_q;
    wr_t    = '0;
    wr_id   = clr_q;
    if (cmd_i.clr_step) begin
      wr_en = 1'b1;
    end else if (cmd_i.cmp) begin
      wr_en   = 1'b1;
      wr_addr = pos_q;
      if (right_win) begin
        wr_t  = r_t_q;
        wr_id = r_id_q;
      end else if (left_win) begin
        wr_t  = l_t_q;
        wr_id = l_id_q;
      end else begin
        wr_t  = cur_t_q;
        wr_id = cur_id_q;
      end
    end
  end

  // Heap memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_t[wr_addr]  <= wr_t;
      mem_id[wr_addr] <= wr_id;
    end
    if (cmd_i.rd) begin
      l_t_q  <= mem_t[l_addr];
      l_id_q <= mem_id[l_addr];
      r_t_q  <= mem_t[r_addr];
      r_id_q <= mem_id[r_addr];
    end
  end

  // Keep a copy of the root, the moving entry and the result
  always_ff @(posedge clk_i) begin
    if (wr_en && (wr_addr == '0)) begin
      root_t_q  <= wr_t;
      root_id_q <= wr_id;
    end
    if (cmd_i.accept) begin
      idx_q    <= efws_pkg::IDX_W'(root_id_q);
      start_q  <= root_t_q;
      cur_t_q  <= next_t;
      cur_id_q <= root_id_q;
    end
  end

  // Worker count, clearing address and sift position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= efws_pkg::CNT_RESET;
      clr_q <= '0;
      pos_q <= '0;
    end else begin
      if (cmd_i.cfg_wr) begin
        cnt_q <= cfg_data_i;
        clr_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_q <= (clr_q == LAST_ADDR) ? '0 : clr_q + AW'(1);
      end
      if (cmd_i.accept) begin
        pos_q <= '0;
      end else if (cmd_i.cmp && (left_win || right_win)) begin
        pos_q <= right_win ? right_w[AW-1:0] : left_w[AW-1:0];
      end
    end
  end

  assign worker_index_o = idx_q;
  assign start_time_o   = start_q;

endmodule

[design/earliest_free_worker_scheduler.sv]
// Earliest-free-worker scheduler: one job duration in, one (worker, start time) out.
// The result is registered and valid in the cycle after the job transfer; the heap sift
// then runs level by level (read children, then compare and write back), and no
// new job is taken until the sift ends.
// Reset and every worker count write start a clearing pass over all MAX_WORKERS
// heap entries, one heap entry a cycle, during which no job is taken. Depends on efws_pkg.
module earliest_free_worker_scheduler #(
  parameter int unsigned MAX_WORKERS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [efws_pkg::DUR_W-1:0]    job_duration_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [efws_pkg::IDX_W-1:0]    worker_index_o,
  output logic [efws_pkg::TIME_W-1:0]   start_time_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [efws_pkg::CNT_W-1:0]    cfg_data_i
);

  efws_pkg::dp_cmd_t cmd;
  efws_pkg::dp_sts_t sts;

  // Sequencer
  efws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Heap datapath
  efws_dp #(
    .MAX_WORKERS (MAX_WORKERS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_data_i     (cfg_data_i),
    .job_duration_i (job_duration_i),
    .worker_index_o (worker_index_o),
    .start_time_o   (start_time_o)
  );

endmodule
